/* hdl/sem_pkg.sv */
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; sobel_edge_magnitude, sem_window and sem_isqrt import this package.
package sem_pkg;

  localparam int PIXEL_BITS      = 8;
  localparam int MAG_BITS        = 8;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 13;

  // |gradient| <= 4 * max pixel
  localparam int GRAD_BITS     = PIXEL_BITS + 2;
  localparam int SQ_BITS       = 2 * GRAD_BITS;
  localparam int RAD_BITS      = 2 * MAG_BITS;
  localparam int RAD_MAX       = (2 ** RAD_BITS) - 1;
  localparam int SQRT_STEPS    = MAG_BITS;
  localparam int SQRT_CNT_BITS = $clog2(SQRT_STEPS);

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [8:0]            window_t;

  typedef struct packed {
    logic req_type;
    pix_t pixel;
  } sem_in_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                frame_end;
  } sem_out_t;

endpackage

/* hdl/sobel_edge_magnitude.sv */
// Sobel 3x3 gradient magnitude over a raster-order grayscale stream. A pixel
// request that gives no result (first row plus one pixel) passes through accept
// and the line memory read-modify-write. A request that gives a result passes
// through accept, memory read, gradient, square and sum, eight steps of the
// bit-serial square root plus the signal that it is done, and the hand-over to
// the output register. Requests are taken one at a time; a result waiting in
// the output register does not block the next request until its own result is
// due. There is no memory clearing pass after reset: stale line memory contents
// only ever reach window taps that the frame border masks to zero.
// Results lag the input by one row plus one pixel; after the last pixel, flush
// requests (req_type = 1) drain the remaining width+1 results. Configuration
// writes restart the frame and are taken only between requests.
// Depends on sem_pkg, sem_window, sem_isqrt.
module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sem_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sem_out_t                 out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int WRST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int HRST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [WW-1:0]        width_q, width_cfg;
  logic [RW-1:0]        height_q, height_cfg;
  logic [CW-1:0]        in_col_q, out_col_q;
  logic [RW-1:0]        in_row_q, out_row_q;
  logic                 emit_q;
  logic                 out_valid_q;
  sem_out_t             out_data_q;
  logic [GRAD_BITS-1:0] gv_abs_q, gh_abs_q;

  logic                 cfg_we;
  logic                 in_acc;
  logic                 is_flush;
  logic                 all_in;
  logic                 early;
  logic                 do_push;
  pix_t                 push_val;
  logic                 in_col_end;
  logic                 out_col_end;
  logic                 last;
  logic                 out_load;
  window_t              win;
  pix_t [8:0]           p;
  logic                 kill_top, kill_bot, kill_left, kill_right;
  logic [GRAD_BITS-1:0] pos_v, neg_v, pos_h, neg_h, gv_abs, gh_abs;
  logic [SQ_BITS-1:0]   sq_v, sq_h;
  logic [SQ_BITS:0]     sq_sum;
  logic [RAD_BITS-1:0]  radicand;
  logic                 root_done;
  logic [MAG_BITS-1:0]  root;

  // request handshake
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_flush    = (in_data_i.req_type == REQ_FLUSH);
  assign all_in      = (in_row_q >= height_q);
  assign early       = (in_row_q == '0) || ((in_row_q == RW'(1)) && (in_col_q == '0));
  assign do_push     = in_acc && (is_flush ? all_in : !all_in);
  assign push_val    = is_flush ? '0 : in_data_i.pixel;
  assign in_col_end  = ((WW'(in_col_q) + WW'(1)) == width_q);
  assign out_col_end = ((WW'(out_col_q) + WW'(1)) == width_q);
  assign last        = (out_row_q == (height_q - RW'(1))) && out_col_end;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // zero and oversize settings are clamped to the legal range
  always_comb begin
    if (cfg_data_i[WIDTH_REG_BITS-1:0] == '0) begin
      width_cfg = WW'(1);
    end else if (32'(cfg_data_i[WIDTH_REG_BITS-1:0]) > 32'(MAX_WIDTH)) begin
      width_cfg = WW'(MAX_WIDTH);
    end else begin
      width_cfg = WW'(cfg_data_i[WIDTH_REG_BITS-1:0]);
    end
    if (cfg_data_i[HEIGHT_REG_BITS-1:0] == '0) begin
      height_cfg = RW'(1);
    end else if (32'(cfg_data_i[HEIGHT_REG_BITS-1:0]) > 32'(MAX_HEIGHT)) begin
      height_cfg = RW'(MAX_HEIGHT);
    end else begin
      height_cfg = RW'(cfg_data_i[HEIGHT_REG_BITS-1:0]);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_push) state_d = ST_READ;
      end
      ST_READ: state_d = emit_q ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQR;
      ST_SQR:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WW'(WRST);
      height_q    <= RW'(HRST);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH: begin
            width_q   <= width_cfg;
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          REG_FRAME_HEIGHT: begin
            height_q  <= height_cfg;
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          default: ;
        endcase
      end else if (do_push) begin
        emit_q <= is_flush || !early;
        if (in_col_end) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + RW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end else if (out_load) begin
        if (last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_end) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  sem_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (do_push),
    .col_i    (in_col_q),
    .value_i  (push_val),
    .window_o (win)
  );

  // taps outside the frame count as zero
  assign kill_top   = (out_row_q == '0);
  assign kill_bot   = ((out_row_q + RW'(1)) == height_q);
  assign kill_left  = (out_col_q == '0);
  assign kill_right = out_col_end;

  always_comb begin
    p[0] = (kill_top || kill_left)  ? '0 : win[0];
    p[1] = kill_top                 ? '0 : win[1];
    p[2] = (kill_top || kill_right) ? '0 : win[2];
    p[3] = kill_left                ? '0 : win[3];
    p[4] = win[4];
    p[5] = kill_right               ? '0 : win[5];
    p[6] = (kill_bot || kill_left)  ? '0 : win[6];
    p[7] = kill_bot                 ? '0 : win[7];
    p[8] = (kill_bot || kill_right) ? '0 : win[8];
  end

  always_comb begin
    pos_v  = GRAD_BITS'(p[6]) + GRAD_BITS'({p[7], 1'b0}) + GRAD_BITS'(p[8]);
    neg_v  = GRAD_BITS'(p[0]) + GRAD_BITS'({p[1], 1'b0}) + GRAD_BITS'(p[2]);
    pos_h  = GRAD_BITS'(p[2]) + GRAD_BITS'({p[5], 1'b0}) + GRAD_BITS'(p[8]);
    neg_h  = GRAD_BITS'(p[0]) + GRAD_BITS'({p[3], 1'b0}) + GRAD_BITS'(p[6]);
    gv_abs = (pos_v >= neg_v) ? (pos_v - neg_v) : (neg_v - pos_v);
    gh_abs = (pos_h >= neg_h) ? (pos_h - neg_h) : (neg_h - pos_h);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_GRAD) begin
      gv_abs_q <= gv_abs;
      gh_abs_q <= gh_abs;
    end
  end

  // anything at or above 2^16 saturates; its root is 255 either way
  always_comb begin
    sq_v   = SQ_BITS'(gv_abs_q) * SQ_BITS'(gv_abs_q);
    sq_h   = SQ_BITS'(gh_abs_q) * SQ_BITS'(gh_abs_q);
    sq_sum = (SQ_BITS+1)'(sq_v) + (SQ_BITS+1)'(sq_h);
    if (sq_sum > (SQ_BITS+1)'(RAD_MAX)) begin
      radicand = '1;
    end else begin
      radicand = RAD_BITS'(sq_sum);
    end
  end

  sem_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SQR),
    .radicand_i (radicand),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.magnitude <= root;
      out_data_q.frame_end <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* hdl/sem_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sem_window.sv */
// Line memory (two rows packed per column entry) and the 3x3 window registers.
// Depends on sem_pkg and sem_ram.
module sem_window import sem_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  pix_t                         value_i,
  output window_t                      window_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                        pending_q;
  logic [CW-1:0]               col_q;
  pix_t                        value_q;
  logic [2*PIXEL_BITS-1:0]     rdata;
  pix_t                        older_rd;
  pix_t                        recent_rd;
  window_t                     win_q;

  // entry = {older row, recent row}; read at push, written back on the next cycle
  sem_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (pending_q),
    .waddr_i (col_q),
    .wdata_i ({recent_rd, value_q}),
    .re_i    (push_i),
    .raddr_i (col_i),
    .rdata_o (rdata)
  );

  assign older_rd  = rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign recent_rd = rdata[PIXEL_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      col_q   <= col_i;
      value_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (pending_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= older_rd;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= recent_rd;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= value_q;
    end
  end

  assign window_o = win_q;

endmodule

/* hdl/sem_isqrt.sv */
// Iterative integer square root, one result bit per cycle (digit recurrence).
// Depends on sem_pkg.
module sem_isqrt import sem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [RAD_BITS-1:0] radicand_i,
  output logic                done_o,
  output logic [MAG_BITS-1:0] root_o
);

  logic                     busy_q;
  logic                     done_q;
  logic [SQRT_CNT_BITS-1:0] cnt_q;
  logic [RAD_BITS-1:0]      rad_q;
  logic [MAG_BITS:0]        rem_q;
  logic [MAG_BITS-1:0]      root_q;
  logic [MAG_BITS+2:0]      rem_try;
  logic [MAG_BITS+2:0]      trial;
  logic [MAG_BITS:0]        rem_d;
  logic [MAG_BITS-1:0]      root_d;

  always_comb begin
    rem_try = {rem_q, rad_q[RAD_BITS-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    if (rem_try >= trial) begin
      rem_d  = (MAG_BITS+1)'(rem_try - trial);
      root_d = {root_q[MAG_BITS-2:0], 1'b1};
    end else begin
      rem_d  = (MAG_BITS+1)'(rem_try);
      root_d = {root_q[MAG_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= SQRT_CNT_BITS'(SQRT_STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
